### hdl/hsv_pkg.sv
// Shared types and fixed constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
package hsv_pkg;

  localparam int HUE_W = 13;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Sector quotient: floor((hue >> frac) / 60) via reciprocal, exact for 13-bit inputs
  localparam int              Q_W       = 8;
  localparam logic [13:0]     SEC_MUL   = 14'd8739;
  localparam int              SEC_SHIFT = 19;
  localparam logic [5:0]      SEC_DEG   = 6'd60;

  // q / 6 via reciprocal, exact for q < 512
  localparam int              Q6_W      = 6;
  localparam logic [7:0]      SIX_MUL   = 8'd171;
  localparam int              SIX_SHIFT = 10;
  localparam logic [Q_W-1:0]  SIX       = 8'd6;

  // Final divide by 9375 (600000 / 64) via reciprocal, exact for y < 2^22
  localparam int              Y_W       = 22;
  localparam int              DIV_M_W   = 23;
  localparam logic [22:0]     DIV_MUL   = 23'd7330078;
  localparam int              DIV_SHIFT = 36;
  localparam int              DIV_POW2  = 6;

  typedef enum logic [2:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
  } hsv_req_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_rsp_t;

  // Hue split into sector and in-sector remainder, with clamped s and v
  typedef struct packed {
    sector_e          sector;
    logic [HUE_W-1:0] rem;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
  } hsv_split_t;

endpackage

### hdl/hsv_sector.sv
// Hue decomposition: three stages turning the hue into sector and remainder, clamping s and v.
// Depends on hsv_pkg.
module hsv_sector import hsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  hsv_req_t   req_i,
  output logic       valid_o,
  output hsv_split_t split_o
);

  localparam int BW = Q_W + 6 + HUE_FRAC_BITS;

  // stage A: clamp, sector quotient
  logic             va_q;
  logic [HUE_W-1:0] hue_a_q;
  logic [PCT_W-1:0] sat_a_q, val_a_q;
  logic [Q_W-1:0]   q_a_q;
  logic [HUE_W-1:0] hh;
  logic [HUE_W+13:0] prod_a;

  assign hh     = req_i.hue >> HUE_FRAC_BITS;
  assign prod_a = (HUE_W+14)'(hh) * (HUE_W+14)'(SEC_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_a_q <= req_i.hue;
    sat_a_q <= (req_i.saturation > PCT_FULL) ? PCT_FULL : req_i.saturation;
    val_a_q <= (req_i.brightness > PCT_FULL) ? PCT_FULL : req_i.brightness;
    q_a_q   <= prod_a[SEC_SHIFT +: Q_W];
  end

  // stage B: remainder within sector, q / 6
  logic             vb_q;
  logic [HUE_W-1:0] rem_b_q;
  logic [Q_W-1:0]   q_b_q;
  logic [Q6_W-1:0]  q6_b_q;
  logic [PCT_W-1:0] sat_b_q, val_b_q;
  logic [BW-1:0]    base_b;
  logic [BW-1:0]    rem_full;
  logic [15:0]      prod_six;

  assign base_b   = BW'(BW'(q_a_q) * BW'(SEC_DEG)) << HUE_FRAC_BITS;
  assign rem_full = BW'(hue_a_q) - base_b;
  assign prod_six = 16'(q_a_q) * 16'(SIX_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_b_q <= rem_full[HUE_W-1:0];
    q_b_q   <= q_a_q;
    q6_b_q  <= prod_six[SIX_SHIFT +: Q6_W];
    sat_b_q <= sat_a_q;
    val_b_q <= val_a_q;
  end

  // stage C: sector = q mod 6
  logic       vc_q;
  hsv_split_t split_c_q;
  logic [Q_W-1:0] sect_full;

  assign sect_full = q_b_q - Q_W'(Q_W'(q6_b_q) * SIX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    split_c_q.sector <= sector_e'(sect_full[2:0]);
    split_c_q.rem    <= rem_b_q;
    split_c_q.sat    <= sat_b_q;
    split_c_q.val    <= val_b_q;
  end

  assign valid_o = vc_q;
  assign split_o = split_c_q;

endmodule

### hdl/hsv_terms.sv
// Term stages: form p, q, t numerators and route them to r, g, b by sector.
// Depends on hsv_pkg.
module hsv_terms import hsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = 4,
  parameter int KW            = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  hsv_split_t       split_i,
  output logic             valid_o,
  output logic [PCT_W-1:0] val_o,
  output logic [KW-1:0]    x_r_o,
  output logic [KW-1:0]    x_g_o,
  output logic [KW-1:0]    x_b_o
);

  localparam int SU   = 60 << HUE_FRAC_BITS;
  localparam int FULL = 100 * SU;

  // stage D: per-term factors, all scaled by 100 * SU
  logic             vd_q;
  sector_e          sect_d_q;
  logic [PCT_W-1:0] val_d_q;
  logic [KW-1:0]    kp_d_q, kq_d_q, kt_d_q;
  logic [KW-1:0]    kv;
  logic [KW-1:0]    rs, rcs;

  assign kv  = KW'(FULL);
  assign rs  = KW'(split_i.rem) * KW'(split_i.sat);
  assign rcs = (KW'(SU) - KW'(split_i.rem)) * KW'(split_i.sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sect_d_q <= split_i.sector;
    val_d_q  <= split_i.val;
    kp_d_q   <= KW'(PCT_FULL - split_i.sat) * KW'(SU);
    kq_d_q   <= kv - rs;
    kt_d_q   <= kv - rcs;
  end

  // stage E: sector routing
  logic             ve_q;
  logic [PCT_W-1:0] val_e_q;
  logic [KW-1:0]    xr_e_q, xg_e_q, xb_e_q;
  logic [KW-1:0]    xr_d, xg_d, xb_d;

  always_comb begin
    unique case (sect_d_q)
      SECT_RY: begin xr_d = kv;     xg_d = kt_d_q; xb_d = kp_d_q; end
      SECT_YG: begin xr_d = kq_d_q; xg_d = kv;     xb_d = kp_d_q; end
      SECT_GC: begin xr_d = kp_d_q; xg_d = kv;     xb_d = kt_d_q; end
      SECT_CB: begin xr_d = kp_d_q; xg_d = kq_d_q; xb_d = kv;     end
      SECT_BM: begin xr_d = kt_d_q; xg_d = kp_d_q; xb_d = kv;     end
      default: begin xr_d = kv;     xg_d = kp_d_q; xb_d = kq_d_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_e_q <= val_d_q;
    xr_e_q  <= xr_d;
    xg_e_q  <= xg_d;
    xb_e_q  <= xb_d;
  end

  assign valid_o = ve_q;
  assign val_o   = val_e_q;
  assign x_r_o   = xr_e_q;
  assign x_g_o   = xg_e_q;
  assign x_b_o   = xb_e_q;

endmodule

### hdl/hsv_scale.sv
// Channel scaling: v * x * 255 / (10000 * SU), truncated, three lanes.
// Depends on hsv_pkg.
module hsv_scale import hsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = 4,
  parameter int KW            = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [PCT_W-1:0] val_i,
  input  logic [KW-1:0]    x_r_i,
  input  logic [KW-1:0]    x_g_i,
  input  logic [KW-1:0]    x_b_i,
  output logic             valid_o,
  output rgb_rsp_t         rgb_o
);

  localparam int NW = PCT_W + KW;
  localparam int PW = Y_W + DIV_M_W;

  logic [KW-1:0]   x_in [3];
  logic [CH_W-1:0] ch   [3];
  logic            vf_q, vg_q, vh_q;

  assign x_in[0] = x_r_i;
  assign x_in[1] = x_g_i;
  assign x_in[2] = x_b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
    end else begin
      vf_q <= valid_i;
      vg_q <= vf_q;
      vh_q <= vg_q;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [NW-1:0]   num_q;
    logic [NW+7:0]   scaled;
    logic [Y_W-1:0]  y_q;
    logic [PW-1:0]   prod;
    logic [CH_W-1:0] ch_q;

    // x255 as shift-subtract, then drop 2^frac * 64 of the divisor
    assign scaled = {num_q, 8'b0} - (NW+8)'(num_q);
    assign prod   = PW'(y_q) * PW'(DIV_MUL);

    always_ff @(posedge clk_i) begin
      num_q <= NW'(val_i) * NW'(x_in[c]);
      y_q   <= scaled[HUE_FRAC_BITS + DIV_POW2 +: Y_W];
      ch_q  <= prod[DIV_SHIFT +: CH_W];
    end

    assign ch[c] = ch_q;
  end

  assign valid_o     = vh_q;
  assign rgb_o.red   = ch[0];
  assign rgb_o.green = ch[1];
  assign rgb_o.blue  = ch[2];

endmodule

### hdl/hsv_to_rgb_convert.sv
// Top level of the HSV to RGB converter.
// Depends on hsv_pkg, hsv_sector, hsv_terms, hsv_scale.
//
// Usage:
//   Request channel: drive req_i (hue in 1/2^HUE_FRAC_BITS degree, saturation
//   and brightness in percent) and raise start_i. A request is taken at every
//   rising edge with start_i high and busy_o low. busy_o is always low, so a
//   new request may be issued every cycle.
//   Result channel: valid_o strobes for one cycle with rgb_o holding 8-bit
//   red, green and blue. Results come out in request order.
// Pipeline: 3 hue split stages, 2 term stages and 3 scaling stages, all
//   registered, lie between the accepting edge and the result strobe.
// Throughput: one request per clock; every stage is a plain register with
//   no feedback, so the rate is set by nothing but the clock.
// Out-of-range inputs: hue above 360 degrees wraps; saturation and
//   brightness above 100 are clamped to 100.
// Reset: rst_ni clears all stage valid bits, so in-flight requests are
//   dropped and no strobe appears until new requests arrive.
// Stalls: the receiver has no way to hold results back; it must take each
//   result in its strobe cycle.
module hsv_to_rgb_convert import hsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  hsv_req_t req_i,
  output logic     valid_o,
  output rgb_rsp_t rgb_o
);

  // width of a term factor, max 100 * 60 * 2^frac
  localparam int KW = $clog2(100 * (60 << HUE_FRAC_BITS) + 1);

  logic             accept;
  logic             split_vld;
  hsv_split_t       split;
  logic             term_vld;
  logic [PCT_W-1:0] term_val;
  logic [KW-1:0]    x_r, x_g, x_b;

  // pipeline never backs up
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  hsv_sector #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_sector (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .req_i  (req_i),
    .valid_o(split_vld),
    .split_o(split)
  );

  hsv_terms #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .KW           (KW)
  ) u_terms (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(split_vld),
    .split_i(split),
    .valid_o(term_vld),
    .val_o  (term_val),
    .x_r_o  (x_r),
    .x_g_o  (x_g),
    .x_b_o  (x_b)
  );

  hsv_scale #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .KW           (KW)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(term_vld),
    .val_i  (term_val),
    .x_r_i  (x_r),
    .x_g_i  (x_g),
    .x_b_i  (x_b),
    .valid_o(valid_o),
    .rgb_o  (rgb_o)
  );

endmodule

### hdl/hsv_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on hsv_pkg and hsv_to_rgb_convert.
module hsv_checker import hsv_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input hsv_req_t req_i,
  input logic     valid_o,
  input rgb_rsp_t rgb_o
);

  localparam int LAT = 8;

  // every request yields a strobe after the fixed latency
  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT valid_o)
    else $error("request not answered after fixed latency");

  // no strobe without a request
  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without matching request");

  // zero brightness gives black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.brightness == '0 |-> ##LAT
      (rgb_o.red == '0 && rgb_o.green == '0 && rgb_o.blue == '0))
    else $error("zero brightness did not give black");

  // zero saturation gives a gray
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.saturation == '0 |-> ##LAT
      (rgb_o.red == rgb_o.green && rgb_o.green == rgb_o.blue))
    else $error("zero saturation did not give gray");

endmodule

bind hsv_to_rgb_convert hsv_checker u_hsv_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .req_i  (req_i),
  .valid_o(valid_o),
  .rgb_o  (rgb_o)
);
